// ===== design/tsf_pkg.sv =====
`timescale 1ns / 1ps
// tsf_pkg: shared widths, constants and types for the triangle scanline fill block.
// No dependencies; used by every module of the block.

package tsf_pkg;

    localparam int X_W       = 10;  // x field width
    localparam int ROW_W     = 6;   // row field width
    localparam int IN_W      = 48;  // packed input item
    localparam int OUT_W     = 32;  // packed result item, padded to whole bytes
    localparam int PROD_W    = 16;  // |dx| * row offset
    localparam int DIV_RADIX = 2;   // quotient bits per divider cycle
    localparam int DIV_STEPS = PROD_W / DIV_RADIX;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [ROW_W-1:0] y;
    } vtx_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture and sort a new triangle
        logic setup;    // select an edge and start its division
        logic edge_ac;  // setup targets the long top-bottom edge
        logic store_a;  // keep division result as first span end
        logic store_b;  // keep division result as second span end
        logic push;     // span goes to the output register, advance row
    } cmd_t;

    // datapath and output stage to controller
    typedef struct packed {
        logic div_done;
        logic row_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [X_W-1:0]   left;
        logic [X_W-1:0]   right;
        logic             last;
    } span_t;

endpackage

// ===== design/tsf_div.sv =====
`timescale 1ns / 1ps
// tsf_div: unsigned restoring divider, two quotient bits per cycle.
// Depends on tsf_pkg for widths.

module tsf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tsf_pkg::PROD_W-1:0]    dividend,
    input  logic [tsf_pkg::ROW_W-1:0]     divisor,
    output logic [tsf_pkg::PROD_W-1:0]    quotient,
    output logic                          done
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [tsf_pkg::CNT_W-1:0]     cnt_reg;
    logic [tsf_pkg::PROD_W-1:0]    quo_reg;
    logic [tsf_pkg::PROD_W-1:0]    quo_next;
    logic [tsf_pkg::ROW_W-1:0]     rem_reg;
    logic [tsf_pkg::ROW_W-1:0]     rem_next;
    logic [tsf_pkg::ROW_W-1:0]     dvs_reg;

    always_comb begin
        logic [tsf_pkg::ROW_W:0]      trial;
        logic [tsf_pkg::ROW_W-1:0]    r;
        logic [tsf_pkg::PROD_W-1:0]   q;
        logic                         ge;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < tsf_pkg::DIV_RADIX; i++) begin
            trial = {r, q[tsf_pkg::PROD_W-1]};
            ge    = trial >= {1'b0, dvs_reg};
            if (ge) begin
                trial = trial - {1'b0, dvs_reg};
            end
            // remainder stays below the divisor, so the top bit is clear
            r = trial[tsf_pkg::ROW_W-1:0];
            q = {q[tsf_pkg::PROD_W-2:0], ge};
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + tsf_pkg::CNT_W'(1);
                if (cnt_reg == tsf_pkg::CNT_W'(tsf_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== design/tsf_dpath.sv =====
`timescale 1ns / 1ps
// tsf_dpath: vertex sort, row counter, edge setup and span end registers.
// Depends on tsf_pkg and tsf_div.

module tsf_dpath #(
    parameter int TILE_ROWS = 64,
    parameter int X_BITS    = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tsf_pkg::cmd_t              cmd,
    input  logic [tsf_pkg::IN_W-1:0]   in_data,
    output logic                       div_done,
    output logic                       row_last,
    output tsf_pkg::span_t             span
);

    localparam int XW = (X_BITS < tsf_pkg::X_W) ? X_BITS : tsf_pkg::X_W;
    localparam logic [tsf_pkg::X_W-1:0]   X_MASK  = tsf_pkg::X_W'((32'd1 << XW) - 32'd1);
    localparam logic [tsf_pkg::ROW_W-1:0] ROW_MAX = tsf_pkg::ROW_W'(TILE_ROWS - 1);

    tsf_pkg::vtx_t v0, v1, v2;
    tsf_pkg::vtx_t s0, s1, s2;
    tsf_pkg::vtx_t top_reg, mid_reg, bot_reg;
    tsf_pkg::vtx_t e0, e1;

    logic [tsf_pkg::ROW_W-1:0]  row_reg;
    logic [tsf_pkg::X_W-1:0]    xa_reg, xb_reg, base_reg;
    logic                       neg_reg;

    logic                       neg;
    logic [tsf_pkg::X_W-1:0]    mag;
    logic [tsf_pkg::ROW_W-1:0]  dy_rel, ey, divisor;
    logic [tsf_pkg::PROD_W-1:0] product, quotient;
    logic [tsf_pkg::X_W-1:0]    edge_x;

    // unpack, mask x and clamp rows to the tile
    always_comb begin
        v0.x = in_data[9:0] & X_MASK;
        v0.y = (in_data[15:10] > ROW_MAX) ? ROW_MAX : in_data[15:10];
        v1.x = in_data[25:16] & X_MASK;
        v1.y = (in_data[31:26] > ROW_MAX) ? ROW_MAX : in_data[31:26];
        v2.x = in_data[41:32] & X_MASK;
        v2.y = (in_data[47:42] > ROW_MAX) ? ROW_MAX : in_data[47:42];
    end

    // three compare-swaps, swap only on a strictly smaller row
    always_comb begin
        tsf_pkg::vtx_t t;
        t  = '0;
        s0 = v0;
        s1 = v1;
        s2 = v2;
        if (s1.y < s0.y) begin
            t = s0; s0 = s1; s1 = t;
        end
        if (s2.y < s0.y) begin
            t = s0; s0 = s2; s2 = t;
        end
        if (s2.y < s1.y) begin
            t = s1; s1 = s2; s2 = t;
        end
    end

    // edge select and operands for the divider
    always_comb begin
        if (cmd.edge_ac) begin
            e0 = top_reg;
            e1 = bot_reg;
        end else if (row_reg < mid_reg.y) begin
            e0 = top_reg;
            e1 = mid_reg;
        end else begin
            e0 = mid_reg;
            e1 = bot_reg;
        end
        neg     = e1.x < e0.x;
        mag     = neg ? (e0.x - e1.x) : (e1.x - e0.x);
        dy_rel  = row_reg - e0.y;
        ey      = e1.y - e0.y;
        // flat edge: row offset is zero too, a divisor of one gives the start x
        divisor = (ey == '0) ? tsf_pkg::ROW_W'(1) : ey;
        product = {{(tsf_pkg::PROD_W - tsf_pkg::X_W){1'b0}}, mag}
                * {{(tsf_pkg::PROD_W - tsf_pkg::ROW_W){1'b0}}, dy_rel};
    end

    tsf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.setup),
        .dividend (product),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // quotient never exceeds |dx|, so the sum stays inside the x range
    assign edge_x = neg_reg ? (base_reg - quotient[tsf_pkg::X_W-1:0])
                            : (base_reg + quotient[tsf_pkg::X_W-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            top_reg <= s0;
            mid_reg <= s1;
            bot_reg <= s2;
            row_reg <= s0.y;
        end else if (cmd.push) begin
            row_reg <= row_reg + tsf_pkg::ROW_W'(1);
        end
        if (cmd.setup) begin
            neg_reg  <= neg;
            base_reg <= e0.x;
        end
        if (cmd.store_a) begin
            xa_reg <= edge_x;
        end
        if (cmd.store_b) begin
            xb_reg <= edge_x;
        end
    end

    assign row_last   = (row_reg == bot_reg.y);
    assign span.row   = row_reg;
    assign span.left  = (xa_reg <= xb_reg) ? xa_reg : xb_reg;
    assign span.right = (xa_reg <= xb_reg) ? xb_reg : xa_reg;
    assign span.last  = row_last;

endmodule

// ===== design/tsf_ctrl.sv =====
`timescale 1ns / 1ps
// tsf_ctrl: sequencer for the scanline fill, one row at a time.
// Depends on tsf_pkg for the command and status structs.

module tsf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  tsf_pkg::stat_t  stat,
    output tsf_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SET_A = 3'd1;
    localparam logic [2:0] S_DIV_A = 3'd2;
    localparam logic [2:0] S_SET_B = 3'd3;
    localparam logic [2:0] S_DIV_B = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SET_A;
                end
            end
            S_SET_A: begin
                cmd.setup  = 1'b1;
                state_next = S_DIV_A;
            end
            S_DIV_A: begin
                if (stat.div_done) begin
                    cmd.store_a = 1'b1;
                    state_next  = S_SET_B;
                end
            end
            S_SET_B: begin
                cmd.setup   = 1'b1;
                cmd.edge_ac = 1'b1;
                state_next  = S_DIV_B;
            end
            S_DIV_B: begin
                if (stat.div_done) begin
                    cmd.store_b = 1'b1;
                    state_next  = S_PUSH;
                end
            end
            S_PUSH: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = stat.row_last ? S_IDLE : S_SET_A;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/triangle_scanline_fill.sv =====
`timescale 1ns / 1ps
// triangle_scanline_fill: top level, joins sequencer, datapath and output register.
// Depends on tsf_pkg, tsf_ctrl, tsf_dpath (which holds tsf_div).
//
// Usage:
//   The s_ channel takes one triangle per item (three vertices, x and row each).
//   The m_ channel returns one span per row from the top vertex row to the
//   bottom vertex row, in increasing row order; m_tlast marks the final span.
//   Rows are clamped to TILE_ROWS-1 and x is masked to X_BITS bits.
//   Each row runs the short-edge division and then the long-edge division
//   through one shared radix-4 divider before its span is pushed.
//   s_tready is high only while no triangle is in work.
//   The output register lets the next row compute while a span waits; if the
//   receiver holds m_tready low, the sequencer stalls before the next push and
//   no span is lost.
//   Reset (aresetn low at a clock edge) returns the sequencer to idle and
//   empties the output register.

module triangle_scanline_fill #(
    parameter int TILE_ROWS = 64,
    parameter int X_BITS    = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // x_first, y_first, x_second, y_second, x_third, y_third
    input  logic [tsf_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // span_row, span_left, span_right, zero padding
    output logic [tsf_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast
);

    tsf_pkg::cmd_t   cmd;
    tsf_pkg::stat_t  stat;
    tsf_pkg::span_t  span;
    logic            div_done;
    logic            row_last;

    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic [tsf_pkg::OUT_W-1:0] m_tdata_reg;
    logic            m_tlast_reg;

    assign stat.div_done = div_done;
    assign stat.row_last = row_last;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    tsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsf_dpath #(
        .TILE_ROWS (TILE_ROWS),
        .X_BITS    (X_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .div_done (div_done),
        .row_last (row_last),
        .span     (span)
    );

    always_comb begin
        if (cmd.push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_tdata_reg <= {{(tsf_pkg::OUT_W - tsf_pkg::ROW_W - 2 * tsf_pkg::X_W){1'b0}},
                            span.right, span.left, span.row};
            m_tlast_reg <= span.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== tb/sv/triangle_scanline_fill_tb.sv =====
`timescale 1ns / 1ps
// triangle_scanline_fill_tb: self-checking bench for the triangle scanline fill block.
// Depends on tsf_pkg and triangle_scanline_fill; a built-in span predictor checks every
// span, across idle and stall patterns on both stream sides.

module triangle_scanline_fill_tb;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam int STUCK_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_PER_PHASE = 40;

    logic                       aclk;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [tsf_pkg::IN_W-1:0]   s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [tsf_pkg::OUT_W-1:0]  m_tdata;
    logic                       m_tlast;

    logic [tsf_pkg::IN_W-1:0]   pending_tris[$];
    tsf_pkg::span_t             spans_due[$];
    idle_mode_t                 idle_mode = IDLE_NONE;
    int                         n_offered = 0;
    int                         n_accepted = 0;
    int                         n_errors = 0;
    int                         stuck_cycles = 0;

    triangle_scanline_fill u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // x at a given row along the edge from (ax, ay) to (bx, by); flat edge gives ax
    function automatic int edge_x_at(int ax, int ay, int bx, int by, int row);
        if (by == ay)
            return ax;
        return ax + ((bx - ax) * (row - ay)) / (by - ay);
    endfunction

    // sort the vertices by row, then queue one span per row top to bottom
    function automatic void predict_spans(logic [tsf_pkg::IN_W-1:0] item);
        int             vx[3];
        int             vy[3];
        int             order[3][2];
        int             k, i, j, t, row, xa, xb;
        tsf_pkg::span_t sp;
        for (k = 0; k < 3; k++) begin
            vx[k] = int'(item[k*16 +: tsf_pkg::X_W]);
            vy[k] = int'(item[k*16 + tsf_pkg::X_W +: tsf_pkg::ROW_W]);
        end
        order = '{'{0, 1}, '{0, 2}, '{1, 2}};
        for (k = 0; k < 3; k++) begin
            i = order[k][0];
            j = order[k][1];
            if (vy[j] < vy[i]) begin
                t = vx[i]; vx[i] = vx[j]; vx[j] = t;
                t = vy[i]; vy[i] = vy[j]; vy[j] = t;
            end
        end
        for (row = vy[0]; row <= vy[2]; row++) begin
            if (row < vy[1])
                xa = edge_x_at(vx[0], vy[0], vx[1], vy[1], row);
            else
                xa = edge_x_at(vx[1], vy[1], vx[2], vy[2], row);
            xb = edge_x_at(vx[0], vy[0], vx[2], vy[2], row);
            if (xa > xb) begin
                t = xa; xa = xb; xb = t;
            end
            sp.row   = row[tsf_pkg::ROW_W-1:0];
            sp.left  = xa[tsf_pkg::X_W-1:0];
            sp.right = xb[tsf_pkg::X_W-1:0];
            sp.last  = (row == vy[2]);
            spans_due.push_back(sp);
        end
    endfunction

    function automatic logic [tsf_pkg::IN_W-1:0] pack_tri(int x0, int y0, int x1, int y1,
                                                          int x2, int y2);
        logic [tsf_pkg::IN_W-1:0] item;
        item = '0;
        item[0  +: tsf_pkg::X_W]   = x0[tsf_pkg::X_W-1:0];
        item[10 +: tsf_pkg::ROW_W] = y0[tsf_pkg::ROW_W-1:0];
        item[16 +: tsf_pkg::X_W]   = x1[tsf_pkg::X_W-1:0];
        item[26 +: tsf_pkg::ROW_W] = y1[tsf_pkg::ROW_W-1:0];
        item[32 +: tsf_pkg::X_W]   = x2[tsf_pkg::X_W-1:0];
        item[42 +: tsf_pkg::ROW_W] = y2[tsf_pkg::ROW_W-1:0];
        return item;
    endfunction

    // mostly short triangles to keep the run quick, with some whose rows range over the whole tile
    function automatic logic [tsf_pkg::IN_W-1:0] random_tri();
        int ys[3];
        int base, k;
        bit tall;
        base = $urandom_range(0, 56);
        tall = ($urandom_range(0, 3) == 0);
        for (k = 0; k < 3; k++)
            ys[k] = tall ? $urandom_range(0, 63) : base + $urandom_range(0, 7);
        // shared rows exercise flat edges and the sort tie rule
        if ($urandom_range(0, 4) == 0)
            ys[$urandom_range(0, 2)] = ys[$urandom_range(0, 2)];
        return pack_tri($urandom_range(0, 1023), ys[0], $urandom_range(0, 1023), ys[1],
                        $urandom_range(0, 1023), ys[2]);
    endfunction

    function automatic bit send_gap();
        return (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 87) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 31);
    endfunction

    function automatic bit recv_stall();
        return (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 87) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 31);
    endfunction

    function automatic void note_mismatch(string what, tsf_pkg::span_t want,
                                          tsf_pkg::span_t got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display({"mismatch (%s): expected row %0d left %0d right %0d last %0d, ",
                      "got row %0d left %0d right %0d last %0d"},
                     what, want.row, want.left, want.right, want.last,
                     got.row, got.left, got.right, got.last);
    endfunction

    // driver: a held item stays until it is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || n_offered == n_accepted) begin
                if (pending_tris.size() != 0 && !send_gap()) begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= pending_tris.pop_front();
                    n_offered <= n_offered + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !recv_stall();
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        tsf_pkg::span_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                n_accepted <= n_accepted + 1;
                predict_spans(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got.row   = m_tdata[0 +: tsf_pkg::ROW_W];
                got.left  = m_tdata[6 +: tsf_pkg::X_W];
                got.right = m_tdata[16 +: tsf_pkg::X_W];
                got.last  = m_tlast;
                if (spans_due.size() == 0)
                    note_mismatch("no span due", '0, got);
                else if (spans_due[0] != got)
                    note_mismatch("wrong span", spans_due.pop_front(), got);
                else
                    void'(spans_due.pop_front());
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_tris.size() != 0 || n_offered != n_accepted || spans_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        idle_mode_t phases[4];
        int p, k;
        phases = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: degenerate rows, full height, flat edges, ties and all vertex orders
        pending_tris.push_back(pack_tri(0, 0, 0, 0, 0, 0));
        pending_tris.push_back(pack_tri(1023, 63, 1023, 63, 1023, 63));
        pending_tris.push_back(pack_tri(5, 10, 1000, 10, 300, 10));
        pending_tris.push_back(pack_tri(0, 0, 1023, 63, 512, 31));
        pending_tris.push_back(pack_tri(1023, 0, 0, 63, 0, 0));
        pending_tris.push_back(pack_tri(0, 63, 1023, 63, 512, 0));
        pending_tris.push_back(pack_tri(1023, 63, 0, 32, 1023, 0));
        pending_tris.push_back(pack_tri(100, 5, 900, 5, 500, 20));
        pending_tris.push_back(pack_tri(900, 5, 100, 5, 500, 20));
        pending_tris.push_back(pack_tri(500, 20, 100, 5, 900, 5));
        pending_tris.push_back(pack_tri(300, 40, 700, 10, 10, 40));
        pending_tris.push_back(pack_tri(0, 0, 512, 32, 1023, 63));
        pending_tris.push_back(pack_tri(1023, 0, 0, 3, 1000, 63));
        pending_tris.push_back(pack_tri(0, 62, 1023, 63, 7, 62));
        pending_tris.push_back(pack_tri(200, 10, 800, 30, 50, 50));
        pending_tris.push_back(pack_tri(200, 10, 50, 50, 800, 30));
        pending_tris.push_back(pack_tri(800, 30, 200, 10, 50, 50));
        pending_tris.push_back(pack_tri(800, 30, 50, 50, 200, 10));
        pending_tris.push_back(pack_tri(50, 50, 200, 10, 800, 30));
        pending_tris.push_back(pack_tri(50, 50, 800, 30, 200, 10));
        wait_drained();

        // each phase ends with the sender held until every span is back
        for (p = 0; p < 4; p++) begin
            idle_mode = phases[p];
            for (k = 0; k < RAND_PER_PHASE; k++)
                pending_tris.push_back(random_tri());
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (n_errors == 0 && spans_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
